@@ design/twada_pkg.sv @@
package twada_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field and register widths
    localparam int TIME_W  = 32;
    localparam int AVG_W   = 32;
    localparam int WIN_W   = 16;
    localparam int THR_W   = 10;
    localparam int PEAK_W  = 15;
    localparam int DEV_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK      = 2'd2;

    localparam logic [WIN_W-1:0]  WIN_RST  = 16'd20;
    localparam logic [THR_W-1:0]  THR_RST  = 10'd5;
    localparam logic [PEAK_W-1:0] PEAK_RST = 15'd0;

    // Arithmetic constants
    localparam longint AVG_MAX = 64'sd2147483647;
    localparam longint AVG_MIN = -64'sd2147483648;
    localparam logic [PEAK_W-1:0] PEAK_MAX = 15'h7fff;
    localparam logic [DEV_W-1:0]  DEV_MAX  = 16'h7fff;
    localparam logic [DEV_W-1:0]  DEV_MIN  = 16'h8000;
    localparam int DEV_SCALE    = 100;
    localparam int PEAK_DET_DIV = 20;
    localparam int PEAK_SET_DIV = 10;

    // Peak divide by ten: x / 10 == (x * PEAK_RECIP) >> PEAK_RECIP_SH for x < 2^19
    localparam int PEAK_SAT_IN   = 327670;   // 10 * 32767; at or above this the peak saturates
    localparam int PEAK_RECIP    = 419431;   // ceil(2^22 / 10)
    localparam int PEAK_RECIP_SH = 22;
    localparam int PK_X_W        = 19;
    localparam int PK_P_W        = 38;

    // Shared divider: dividend up to |diff| * gap < 2^48, divisor up to 2^31
    localparam int MUL_B_W   = 16;
    localparam int DIV_N     = 48;
    localparam int DIV_D     = 32;
    localparam int DIV_CW    = 6;
    localparam int DEV_NUM_W = 39;   // (2^32 - 1) * 100 < 2^39
    localparam int PTHR_W    = 21;

    typedef struct packed {
        logic              start;
        logic [DIV_N-1:0]  dividend;
        logic [DIV_D-1:0]  divisor;
        logic [DIV_CW-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEAK,
        S_PEAK_DIV,
        S_AVG,
        S_AVG_MUL,
        S_AVG_DIV,
        S_AVG_WAIT,
        S_DEV,
        S_DEV_MUL,
        S_DEV_DIV,
        S_DEV_WAIT,
        S_FIN
    } t_state;

endpackage

@@ design/twada_if.sv @@
interface twada_smp_if
    import twada_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [TIME_W-1:0]             sample_time;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, sample_time, sample_value, input ready);
    modport sink   (input valid, sample_time, sample_value, output ready);
endinterface

interface twada_res_if
    import twada_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [AVG_W-1:0] average_value;
    logic signed [DEV_W-1:0] deviation_percent;
    logic [PEAK_W-1:0]       alarm_level;

    modport source (output valid, average_value, deviation_percent, alarm_level, input ready);
    modport sink   (input valid, average_value, deviation_percent, alarm_level, output ready);
endinterface

@@ design/twada_div.sv @@
module twada_div
    import twada_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_N-1:0]  r_quo;
    logic [DIV_D-1:0]  r_rem;
    logic [DIV_D-1:0]  r_dvs;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_D:0]   rem_sh;
    logic [DIV_D+1:0] trial;
    logic             ge;

    // One restoring step per cycle; quotient bits shift in as dividend bits shift out
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_N-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = !trial[DIV_D+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N-2:0], ge};
            r_rem <= ge ? trial[DIV_D-1:0] : rem_sh[DIV_D-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ design/time_weighted_average_deviation_alarm_core.sv @@
// Time-weighted average with deviation alarm. Each sample transaction carries a timestamp
// and a signed value; the block returns one result transaction with the new Q.FRAC_BITS
// running average, the truncated percent deviation of the sample from that average and
// the alarm level (fixed or auto-tracked peak, or zero when the deviation does not exceed
// the threshold). The divisions by the window and by the average run on a single shared
// divider that retires one quotient bit per cycle; the peak's divide by ten is a reciprocal
// multiply in its own state. The shortest item has the average loaded, a zero average and no
// peak update; the longest has a peak update, an average blend with 48 divider steps and a
// deviation with 39 steps. The sample port is not ready while an item is in progress. A
// finished result sits in an output register, so the next sample is taken while it waits.
// Configuration writes take effect at once and are meant for idle periods.
module time_weighted_average_deviation_alarm_core
    import twada_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    twada_smp_if.sink             i_smp,
    twada_res_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SX = SAMPLE_BITS + FRAC_BITS;
    localparam int SW = (SX > AVG_W + 1) ? SX : AVG_W + 1;
    localparam int PW = ((SAMPLE_BITS > PTHR_W) ? SAMPLE_BITS : PTHR_W) + 1;

    // Configuration
    logic [WIN_W-1:0]  r_win;
    logic [THR_W-1:0]  r_thr;
    logic [PEAK_W-1:0] r_fpk;

    // Block state
    t_state                  r_state, n_state;
    logic [TIME_W-1:0]       r_prev;
    logic signed [AVG_W-1:0] r_avg;
    logic                    r_primed;
    logic [PEAK_W-1:0]       r_tp;

    // Per-item working registers
    logic [TIME_W-1:0]             r_t;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [AVG_W-1:0]       r_s;
    logic                          r_load;
    logic [WIN_W-1:0]              r_gap;
    logic                          r_neg;
    logic [AVG_W-1:0]              r_mag;
    logic [DIV_N-1:0]              r_prod;
    logic signed [DEV_W-1:0]       r_dev;

    // Output register
    logic                    r_out_valid;
    logic signed [AVG_W-1:0] r_out_avg;
    logic signed [DEV_W-1:0] r_out_dev;
    logic [PEAK_W-1:0]       r_out_lvl;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                    in_acc;
    logic                    out_load;
    logic signed [SW-1:0]    y_shift;
    logic signed [AVG_W-1:0] s_sat;
    logic [TIME_W-1:0]       gap_full;
    logic                    load_c;
    logic [PTHR_W-1:0]       peak_thr;
    logic signed [PW-1:0]    y_pk;
    logic signed [PW-1:0]    thr_s;
    logic                    peak_hit;
    logic                    pk_sat;
    logic [PK_X_W-1:0]       pk_x;
    logic [PK_P_W-1:0]       pk_prod;
    logic [PEAK_W-1:0]       pk_new;
    logic signed [AVG_W-1:0] sub_a;
    logic signed [AVG_W-1:0] sub_b;
    logic signed [AVG_W:0]   diff;
    logic [AVG_W-1:0]        mag_c;
    logic [MUL_B_W-1:0]      mul_b;
    logic [DIV_N-1:0]        mul_p;
    logic [AVG_W-1:0]        q_avg;
    logic signed [AVG_W+1:0] q_s;
    logic signed [AVG_W+1:0] avg_sum;
    logic [AVG_W-1:0]        avg_abs;
    logic [DIV_N-1:0]        q_dev;
    logic signed [DEV_W-1:0] dev_sat;
    logic [PEAK_W-1:0]       lvl_sel;
    logic                    alarm;

    twada_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc   = i_smp.valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    always_comb begin
        // scaled sample, saturated to the signed 32-bit range
        y_shift = SW'(r_y) <<< FRAC_BITS;
        if (y_shift > SW'(AVG_MAX)) begin
            s_sat = AVG_W'(AVG_MAX);
        end else if (y_shift < SW'(AVG_MIN)) begin
            s_sat = AVG_W'(AVG_MIN);
        end else begin
            s_sat = y_shift[AVG_W-1:0];
        end

        gap_full = r_t - r_prev;
        load_c   = (r_t == '0) || !r_primed || (gap_full >= TIME_W'(r_win));

        // sample/20 > peak  <=>  sample >= 20 * (peak + 1)
        peak_thr = PTHR_W'((PTHR_W'(r_tp) + PTHR_W'(1)) * PTHR_W'(PEAK_DET_DIV));
        y_pk     = PW'(r_y);
        thr_s    = PW'(peak_thr);
        peak_hit = (r_fpk == '0) && (y_pk >= thr_s);

        // new peak = sample/10, saturated; the sample is positive whenever this is used
        pk_sat  = (y_pk >= PW'(PEAK_SAT_IN));
        pk_x    = y_pk[PK_X_W-1:0];
        pk_prod = PK_P_W'(pk_x) * PK_P_W'(PEAK_RECIP);
        pk_new  = pk_sat ? PEAK_MAX : pk_prod[PEAK_RECIP_SH +: PEAK_W];

        if (r_state == S_AVG) begin
            sub_a = r_s;
            sub_b = r_avg;
        end else begin
            sub_a = r_avg;
            sub_b = r_s;
        end
        diff  = (AVG_W+1)'(sub_a) - (AVG_W+1)'(sub_b);
        mag_c = diff[AVG_W] ? AVG_W'(-diff) : diff[AVG_W-1:0];

        mul_b = (r_state == S_AVG_MUL) ? r_gap : MUL_B_W'(DEV_SCALE);
        mul_p = r_mag * mul_b;

        q_avg   = div_rsp.quotient[AVG_W-1:0];
        q_s     = r_neg ? -$signed({2'b00, q_avg}) : $signed({2'b00, q_avg});
        avg_sum = (AVG_W+2)'(r_avg) + q_s;

        avg_abs = r_avg[AVG_W-1] ? AVG_W'(-r_avg) : r_avg;

        q_dev = div_rsp.quotient;
        if (!r_avg[AVG_W-1]) begin
            dev_sat = (q_dev > DIV_N'(DEV_MAX)) ? DEV_MAX : q_dev[DEV_W-1:0];
        end else begin
            dev_sat = (q_dev > DIV_N'(DEV_MIN)) ? DEV_MIN : -q_dev[DEV_W-1:0];
        end

        lvl_sel = (r_fpk != '0) ? r_fpk : r_tp;
        alarm   = r_dev > $signed({{(DEV_W-THR_W){1'b0}}, r_thr});
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = DIV_D'(r_win);
        div_req.steps    = DIV_CW'(DIV_N);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                n_state = peak_hit ? S_PEAK_DIV : S_AVG;
            end
            S_PEAK_DIV: begin
                n_state = S_AVG;
            end
            S_AVG: begin
                n_state = r_load ? S_DEV : S_AVG_MUL;
            end
            S_AVG_MUL: begin
                n_state = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                div_req.start = 1'b1;
                n_state       = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                n_state = (r_avg == '0) ? S_FIN : S_DEV_MUL;
            end
            S_DEV_MUL: begin
                n_state = S_DEV_DIV;
            end
            S_DEV_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod << (DIV_N - DEV_NUM_W);
                div_req.divisor  = DIV_D'(avg_abs);
                div_req.steps    = DIV_CW'(DEV_NUM_W);
                n_state          = S_DEV_WAIT;
            end
            S_DEV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RST;
            r_thr       <= THR_RST;
            r_fpk       <= PEAK_RST;
            r_prev      <= '0;
            r_avg       <= '0;
            r_primed    <= 1'b0;
            r_tp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW:    r_win <= i_cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_PEAK:      r_fpk <= i_cfg_data[PEAK_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_PEAK) begin
                r_prev <= r_t;
            end
            if (r_state == S_PEAK_DIV) begin
                r_tp <= pk_new;
            end
            if (r_state == S_AVG && r_load) begin
                r_avg    <= r_s;
                r_primed <= 1'b1;
            end
            if (r_state == S_AVG_WAIT && div_rsp.done) begin
                r_avg <= avg_sum[AVG_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_t <= i_smp.sample_time;
            r_y <= SAMPLE_BITS'(i_smp.sample_value);
        end
        if (r_state == S_PEAK) begin
            r_s    <= s_sat;
            r_load <= load_c;
            r_gap  <= gap_full[WIN_W-1:0];
        end
        // hold sign and magnitude of the difference for the multiplier
        if ((r_state == S_AVG && !r_load) || (r_state == S_DEV && r_avg != '0)) begin
            r_neg <= diff[AVG_W];
            r_mag <= mag_c;
        end
        if (r_state == S_AVG_MUL || r_state == S_DEV_MUL) begin
            r_prod <= mul_p;
        end
        if (r_state == S_DEV && r_avg == '0) begin
            r_dev <= (r_s != '0) ? DEV_MAX : '0;
        end
        if (r_state == S_DEV_WAIT && div_rsp.done) begin
            r_dev <= dev_sat;
        end
        if (out_load) begin
            r_out_avg <= r_avg;
            r_out_dev <= r_dev;
            r_out_lvl <= alarm ? lvl_sel : '0;
        end
    end

    assign i_smp.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_out_valid;
    assign o_res.average_value     = r_out_avg;
    assign o_res.deviation_percent = r_out_dev;
    assign o_res.alarm_level       = r_out_lvl;

`ifndef SYNTHESIS
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_AVG_WAIT || r_state == S_DEV_WAIT))
        else $error("divider result with no state waiting for it");

    a_wait_has_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG_WAIT || r_state == S_DEV_WAIT)
        |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_primed))
        else $error("primed flag dropped without reset");

    a_peak_update_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_tp)) |-> ($past(r_state) == S_PEAK_DIV))
        else $error("tracked peak changed outside its update step");
`endif

endmodule
